>>> rtl/u8dec_pkg.sv
// shared types, constants and lead byte helpers for the utf-8 style index decoder
// no dependencies

package u8dec_pkg;

    localparam int VALUE_W = 31;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 3;

    localparam logic [BYTE_W-1:0] B00111111 = 8'h3F;
    localparam logic [BYTE_W-1:0] B10000000 = 8'h80;
    localparam logic [BYTE_W-1:0] B11000000 = 8'hC0;
    localparam logic [BYTE_W-1:0] B00011111 = 8'h1F;
    localparam logic [BYTE_W-1:0] B11111101 = 8'hFD;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CONT = 2'd1,
        STATUS_BAD_LEAD = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_stage;

    // continuation bytes that follow a multi-byte lead (0xc0 to 0xfd)
    function automatic logic [PEND_W-1:0] cont_count(input logic [BYTE_W-1:0] b);
        logic [PEND_W-1:0] n;
        if (b < 8'hE0) begin
            n = 3'd1;
        end else if (b < 8'hF0) begin
            n = 3'd2;
        end else if (b < 8'hF8) begin
            n = 3'd3;
        end else if (b < 8'hFC) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    // value bits carried by a lead byte
    function automatic logic [BYTE_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                    input logic [PEND_W-1:0] n);
        return b & (B00011111 >> (n - 3'd1));
    endfunction

endpackage

>>> rtl/u8dec_byte_if.sv
// byte channel: valid, ready and one raw byte
// depends on u8dec_pkg

interface u8dec_byte_if
    import u8dec_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

>>> rtl/u8dec_code_if.sv
// result channel: valid, ready, decoded value and status
// depends on u8dec_pkg

interface u8dec_code_if
    import u8dec_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] code_value;
    t_status            status;

    modport source (output valid, output code_value, output status, input ready);
    modport sink (input valid, input code_value, input status, output ready);
endinterface

>>> rtl/utf8_index_stream_decoder.sv
// top level of the utf-8 style index decoder, 6-byte 31-bit form
// depends on u8dec_pkg, u8dec_byte_if, u8dec_code_if, u8dec_in_reg, u8dec_step

// Takes one byte per clock cycle while ready is high; the byte that ends a sequence
// is registered in the input register and then goes through the decode logic into
// the result register, which holds the result. Single-byte values and bad lead
// bytes give a result at once; a multi-byte sequence gives one result on its last
// byte, with status bad continuation if any continuation byte lacked the 10 prefix.
// Ready drops only while a result is held and not taken by the sink.

module utf8_index_stream_decoder
    import u8dec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8dec_byte_if.sink    i_byte,
    u8dec_code_if.source  o_code
);

    t_byte_stage stage;
    logic        take;

    u8dec_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_stage (stage)
    );

    u8dec_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_code  (o_code)
    );

endmodule

>>> rtl/u8dec_in_reg.sv
// input register stage of the decoder
// depends on u8dec_pkg and u8dec_byte_if

module u8dec_in_reg
    import u8dec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8dec_byte_if.sink    i_byte,
    input  logic          i_take,
    output t_byte_stage   o_stage
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    assign i_byte.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_data <= i_byte.byte_in;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

>>> rtl/u8dec_step.sv
// sequence state, decode of one byte and result register
// depends on u8dec_pkg and u8dec_code_if

module u8dec_step
    import u8dec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_byte_stage   i_stage,
    output logic          o_take,
    u8dec_code_if.source  o_code
);

    logic [PEND_W-1:0]  r_pending, n_pending;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_bad, n_bad;
    logic               r_valid, n_valid;
    logic [VALUE_W-1:0] r_value, n_value;
    t_status            r_status, n_status;

    logic [VALUE_W-1:0] acc_sh;
    logic               bad_now;
    logic [PEND_W-1:0]  pend_dec;
    logic [PEND_W-1:0]  cnt;

    assign o_take   = i_stage.valid && (!r_valid || o_code.ready);
    assign acc_sh   = {r_acc[VALUE_W-7:0], i_stage.data[5:0]};
    assign bad_now  = r_bad || ((i_stage.data & B11000000) != B10000000);
    assign pend_dec = r_pending - 3'd1;
    assign cnt      = cont_count(i_stage.data);

    always_comb begin
        n_pending = r_pending;
        n_acc     = r_acc;
        n_bad     = r_bad;
        n_valid   = r_valid && !o_code.ready;
        n_value   = r_value;
        n_status  = r_status;
        if (o_take) begin
            n_valid = 1'b0;
            if (r_pending == '0) begin
                if (i_stage.data < B10000000) begin
                    n_valid  = 1'b1;
                    n_value  = VALUE_W'(i_stage.data);
                    n_status = STATUS_OK;
                end else if (i_stage.data < B11000000 || i_stage.data > B11111101) begin
                    n_valid  = 1'b1;
                    n_value  = '0;
                    n_status = STATUS_BAD_LEAD;
                end else begin
                    n_pending = cnt;
                    n_acc     = VALUE_W'(lead_bits(i_stage.data, cnt));
                    n_bad     = 1'b0;
                end
            end else begin
                n_pending = pend_dec;
                if (pend_dec == '0) begin
                    n_valid  = 1'b1;
                    n_value  = bad_now ? '0 : acc_sh;
                    n_status = bad_now ? STATUS_BAD_CONT : STATUS_OK;
                    n_acc    = '0;
                    n_bad    = 1'b0;
                end else begin
                    n_acc = acc_sh;
                    n_bad = bad_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
            r_bad     <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_bad     <= n_bad;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_code.valid      = r_valid;
    assign o_code.code_value = r_value;
    assign o_code.status     = r_status;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != STATUS_OK |-> r_value == '0)
        else $error("error result carries a non-zero value");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd5)
        else $error("pending count out of range");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_pending == 3'd1 |=> r_valid && r_pending == '0)
        else $error("sequence end gave no result");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_pending == '0 && !i_stage.data[7]
        |=> r_valid && r_status == STATUS_OK && r_value == VALUE_W'($past(i_stage.data)))
        else $error("single byte value not passed through");

    a_mid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_pending > 3'd1 |=> !r_valid)
        else $error("result inside an open sequence");
`endif

endmodule
